/* hdl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and codes for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // One input word: a raw character or an end-of-input mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } in_t;

    // One result word.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic [23:0] lines_seen;
    } out_t;

    // Result status codes.
    localparam logic [1:0] ST_BYTE    = 2'd0;
    localparam logic [1:0] ST_CLEAN   = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_ILLEGAL = 2'd3;

    localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;

    // Character class as decided by the front end.
    typedef enum logic [2:0] {
        CLS_SEXTET,
        CLS_LF,
        CLS_CR,
        CLS_SPACE,
        CLS_END,
        CLS_BAD
    } cls_t;

    // Classified word passed from the front end to the back end.
    typedef struct packed {
        cls_t       cls;
        logic [5:0] sextet;
    } cls_word_t;

endpackage

/* hdl/base64_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder with whitespace skipping and line counting.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                      | Word
//   --------+----------------------------+-------------------------------------
//   input   | s_valid, s_ready, s_data   | ch, end_of_input
//   result  | m_valid, m_ready, m_data   | data_byte, status, lines_seen
//
// The decoder takes one character per clock and keeps that pace as long as
// results are taken. The rate is set by the back end, which updates the bit
// accumulator and line count for each word it takes.
// A result reaches m_data by way of the classify register, which loads at the
// accepting edge, then the queue and then the result register.
// Reset (aresetn low at a clock edge) clears the accumulator, the line count,
// the halt flag, the queue and both valid flags.
// A stalled result side fills the result register, then the queue, then the
// classify register, after which s_ready drops; the front keeps accepting
// until all three are full.
//
// The front end classifies each character (sextet, CR, LF, blank, stream
// end, illegal) and computes its six-bit value. Classified words wait in a
// small FIFO. The back end consumes them: sextets shift into the accumulator
// and release a byte whenever eight bits are present, line ends advance a
// saturating counter, a stream end reports a clean or truncated finish, and
// an illegal character reports an error and halts decoding until reset.
// While halted, words are still drained from the queue but produce nothing.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit #(
    parameter int QUEUE_ADDR_W = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  b64d_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output b64d_pkg::out_t m_data
);
    import b64d_pkg::*;

    logic      f_valid;
    logic      f_ready;
    cls_word_t f_word;
    logic      q_valid;
    logic      q_ready;
    cls_word_t q_word;

    b64d_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_word  (f_word)
    );

    b64d_queue #(
        .ADDR_W (QUEUE_ADDR_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_word  (f_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    b64d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_word  (q_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hdl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input words, classifies each character and registers the result.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::in_t       s_data,
    output logic                f_valid,
    input  logic                f_ready,
    output b64d_pkg::cls_word_t f_word
);
    import b64d_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cls_word_t word_reg;
    cls_word_t word_next;

    function automatic cls_word_t classify(input in_t d);
        cls_word_t w;
        w.cls    = CLS_BAD;
        w.sextet = 6'd0;
        if (d.end_of_input) begin
            w.cls = CLS_END;
        end else if (d.ch >= 8'h41 && d.ch <= 8'h5A) begin
            w.cls    = CLS_SEXTET;
            w.sextet = 6'(d.ch - 8'h41);
        end else if (d.ch >= 8'h61 && d.ch <= 8'h7A) begin
            w.cls    = CLS_SEXTET;
            w.sextet = 6'(d.ch - 8'h61 + 8'd26);
        end else if (d.ch >= 8'h30 && d.ch <= 8'h39) begin
            w.cls    = CLS_SEXTET;
            w.sextet = 6'(d.ch - 8'h30 + 8'd52);
        end else begin
            unique case (d.ch)
                8'h2B:          begin w.cls = CLS_SEXTET; w.sextet = 6'd62; end
                8'h2F:          begin w.cls = CLS_SEXTET; w.sextet = 6'd63; end
                8'h0A:          w.cls = CLS_LF;
                8'h0D:          w.cls = CLS_CR;
                8'h20, 8'h09:   w.cls = CLS_SPACE;
                8'h3D, 8'h3C:   w.cls = CLS_END;
                default:        w.cls = CLS_BAD;
            endcase
        end
        return w;
    endfunction

    // The stage refills whenever its word moves on in the same cycle.
    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_word  = word_reg;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (s_ready) begin
            valid_next = s_valid;
            word_next  = classify(s_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        word_reg <= word_next;
    end

endmodule

/* hdl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int ADDR_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  b64d_pkg::cls_word_t push_word,
    output logic                pop_valid,
    input  logic                pop_ready,
    output b64d_pkg::cls_word_t pop_word
);
    import b64d_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    cls_word_t         entry_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [ADDR_W:0]   count_reg;
    logic [ADDR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (ADDR_W+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* hdl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Executes classified words: bit accumulator, line count, halt and results.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  b64d_pkg::cls_word_t q_word,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::out_t      m_data
);
    import b64d_pkg::*;

    logic [5:0]  bit_store_reg;
    logic [5:0]  bit_store_next;
    logic [2:0]  bit_count_reg;
    logic [2:0]  bit_count_next;
    logic        after_return_reg;
    logic        after_return_next;
    logic        halted_reg;
    logic        halted_next;
    logic [23:0] line_total_reg;
    logic [23:0] line_total_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_t        out_reg;
    out_t        out_next;
    logic [11:0] acc;
    logic        take;
    logic        emit;
    logic [7:0]  emit_byte;
    logic [1:0]  emit_status;
    logic        line_inc;

    // A word is taken only when the result slot is free or draining now.
    assign q_ready = !out_valid_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign acc     = {bit_store_reg, q_word.sextet};
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        bit_store_next    = bit_store_reg;
        bit_count_next    = bit_count_reg;
        after_return_next = after_return_reg;
        halted_next       = halted_reg;
        emit              = 1'b0;
        emit_byte         = 8'd0;
        emit_status       = ST_BYTE;
        line_inc          = 1'b0;

        if (take && !halted_reg) begin
            after_return_next = 1'b0;
            unique case (q_word.cls)
                CLS_LF: begin
                    line_inc = !after_return_reg;
                end
                CLS_CR: begin
                    line_inc          = 1'b1;
                    after_return_next = 1'b1;
                end
                CLS_SPACE: begin
                end
                CLS_END: begin
                    emit           = 1'b1;
                    emit_status    = (bit_count_reg != 3'd0 && bit_store_reg != 6'd0)
                                     ? ST_TRUNC : ST_CLEAN;
                    bit_store_next = 6'd0;
                    bit_count_next = 3'd0;
                end
                CLS_BAD: begin
                    emit        = 1'b1;
                    emit_status = ST_ILLEGAL;
                    halted_next = 1'b1;
                end
                CLS_SEXTET: begin
                    unique case (bit_count_reg)
                        3'd0: begin
                            bit_store_next = q_word.sextet;
                            bit_count_next = 3'd6;
                        end
                        3'd2: begin
                            emit           = 1'b1;
                            emit_byte      = acc[7:0];
                            bit_store_next = 6'd0;
                            bit_count_next = 3'd0;
                        end
                        3'd4: begin
                            emit           = 1'b1;
                            emit_byte      = acc[9:2];
                            bit_store_next = {4'd0, acc[1:0]};
                            bit_count_next = 3'd2;
                        end
                        default: begin
                            // Six bits held; odd counts never occur.
                            emit           = 1'b1;
                            emit_byte      = acc[11:4];
                            bit_store_next = {2'd0, acc[3:0]};
                            bit_count_next = 3'd4;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        line_total_next = line_total_reg;
        if (line_inc && line_total_reg != LINE_MAX) begin
            line_total_next = line_total_reg + 24'd1;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next      = 1'b1;
            out_next.data_byte  = emit_byte;
            out_next.status     = emit_status;
            out_next.lines_seen = line_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_store_reg    <= 6'd0;
            bit_count_reg    <= 3'd0;
            after_return_reg <= 1'b0;
            halted_reg       <= 1'b0;
            line_total_reg   <= 24'd0;
            out_valid_reg    <= 1'b0;
        end else begin
            bit_store_reg    <= bit_store_next;
            bit_count_reg    <= bit_count_next;
            after_return_reg <= after_return_next;
            halted_reg       <= halted_next;
            line_total_reg   <= line_total_next;
            out_valid_reg    <= out_valid_next;
        end
        out_reg <= out_next;
    end

endmodule

/* hdl/b64d_checker.sv */
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level assertions for the base64 stream decoder, attached by bind.
// ----------------------------------------------------------------------------
module b64d_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input b64d_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input b64d_pkg::out_t m_data
);
    import b64d_pkg::*;

    logic        halt_seen_reg;
    logic [23:0] last_lines_reg;
    logic        m_accept;

    assign m_accept = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_seen_reg  <= 1'b0;
            last_lines_reg <= 24'd0;
        end else if (m_accept) begin
            last_lines_reg <= m_data.lines_seen;
            if (m_data.status == ST_ILLEGAL) begin
                halt_seen_reg <= 1'b1;
            end
        end
    end

    // Once an illegal character has been reported, nothing more comes out.
    a_silent_after_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_seen_reg |-> !m_valid)
        else $error("result after illegal character report");

    // The line count carried on results never goes backwards.
    a_lines_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_accept |-> (m_data.lines_seen >= last_lines_reg))
        else $error("lines_seen decreased");

    // Only byte results carry data.
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_BYTE) |-> (m_data.data_byte == 8'd0))
        else $error("nonzero data_byte on a status result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed while stalled");

    // A waiting input word holds until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
        else $error("input word changed while waiting");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
